FILE: src/asps_pkg.sv
// ---------------------------------------------------------------------------
// asps_pkg: shared types and constants for the aliquot sum core
// Widths of the number and the sum, the sequencer states and the
// result bundle of the iterative divider.
// ---------------------------------------------------------------------------
package asps_pkg;

  localparam int NUM_BITS = 32;
  localparam int SUM_BITS = 36;
  // Accumulator is wide enough to hold the exact sum before saturation.
  localparam int ACC_BITS = (NUM_BITS + 8 > SUM_BITS) ? NUM_BITS + 8 : SUM_BITS + 1;
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_CHECK,
    S_ADDCO,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quo;
    logic [NUM_BITS-1:0] rem;
  } div_res_t;

endpackage

FILE: src/asps_div.sv
// ---------------------------------------------------------------------------
// asps_div: restoring divider, one quotient bit per cycle
// Loads dividend and divisor on start, runs NUM_BITS steps and pulses done
// with the quotient and remainder, which then hold until the next start.
// ---------------------------------------------------------------------------
module asps_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [asps_pkg::NUM_BITS-1:0] dividend,
  input  logic [asps_pkg::NUM_BITS-1:0] divisor,
  output asps_pkg::div_res_t            res
);

  logic [asps_pkg::NUM_BITS-1:0] rem_r;
  logic [asps_pkg::NUM_BITS-1:0] quo_r;
  logic [asps_pkg::NUM_BITS-1:0] den_r;
  logic [asps_pkg::CNT_BITS-1:0] cnt_r;
  logic                          done_r;

  logic [asps_pkg::NUM_BITS:0]   rem_shift;
  logic [asps_pkg::NUM_BITS:0]   diff;

  assign rem_shift = {rem_r, quo_r[asps_pkg::NUM_BITS-1]};
  assign diff      = rem_shift - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == asps_pkg::CNT_BITS'(1));
      if (start) begin
        rem_r <= '0;
        quo_r <= dividend;
        den_r <= divisor;
        cnt_r <= asps_pkg::CNT_BITS'(asps_pkg::NUM_BITS);
      end else if (cnt_r != '0) begin
        // A borrow out of the top bit means the trial subtraction failed.
        if (!diff[asps_pkg::NUM_BITS]) begin
          rem_r <= diff[asps_pkg::NUM_BITS-1:0];
          quo_r <= {quo_r[asps_pkg::NUM_BITS-2:0], 1'b1};
        end else begin
          rem_r <= rem_shift[asps_pkg::NUM_BITS-1:0];
          quo_r <= {quo_r[asps_pkg::NUM_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r - asps_pkg::CNT_BITS'(1);
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule

FILE: src/aliquot_sum_perfect_test_core.sv
// ---------------------------------------------------------------------------
// aliquot_sum_perfect_test_core: proper divisor sum and perfect test
// Trial divides the number by each candidate from 2 while the candidate
// does not exceed the quotient, adding each divisor and its cofactor.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   input   | in_valid, in_ready, in_number       | in
//   result  | out_valid, out_ready,               | out
//           | out_divisor_sum, out_is_perfect     |
//
// Each candidate takes a run through the shared bit-serial divider and a check,
// plus a step to add the cofactor when it divides the number with a cofactor
// that differs from it, so an item's run time grows with the square root of
// the number.
// Reset clears the sequencer, the divider count and the output valid.
// A held result stalls only the final write; the search itself runs on.
// ---------------------------------------------------------------------------
module aliquot_sum_perfect_test_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [asps_pkg::NUM_BITS-1:0] in_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [asps_pkg::SUM_BITS-1:0] out_divisor_sum,
  output logic                          out_is_perfect
);

  asps_pkg::state_t state_r, state_nxt;

  logic [asps_pkg::NUM_BITS-1:0] num_r;
  logic [asps_pkg::NUM_BITS-1:0] cand_r;
  logic [asps_pkg::ACC_BITS-1:0] acc_r;
  logic                          small_r;
  logic                          out_valid_r;
  logic [asps_pkg::SUM_BITS-1:0] sum_out_r;
  logic                          perf_out_r;

  asps_pkg::div_res_t            div_res;
  logic                          div_start;
  logic                          accepted;
  logic                          cand_over;
  logic                          divides;
  logic                          co_differs;
  logic                          add_en;
  logic                          load_out;
  logic [asps_pkg::NUM_BITS-1:0] addend;
  logic [asps_pkg::ACC_BITS-1:0] acc_sum;
  logic                          saturate;

  asps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (cand_r),
    .res      (div_res)
  );

  assign accepted   = in_valid && in_ready;
  assign cand_over  = cand_r > div_res.quo;
  assign divides    = (div_res.rem == '0);
  assign co_differs = (div_res.quo != cand_r);

  // Single shared adder: the candidate in the check state, the cofactor after.
  assign addend  = (state_r == asps_pkg::S_ADDCO) ? div_res.quo : cand_r;
  assign acc_sum = acc_r + asps_pkg::ACC_BITS'(addend);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asps_pkg::S_IDLE: begin
        if (accepted) begin
          state_nxt = (in_number < asps_pkg::NUM_BITS'(2)) ? asps_pkg::S_FINISH
                                                           : asps_pkg::S_START;
        end
      end
      asps_pkg::S_START: state_nxt = asps_pkg::S_WAIT;
      asps_pkg::S_WAIT: begin
        if (div_res.done) state_nxt = asps_pkg::S_CHECK;
      end
      asps_pkg::S_CHECK: begin
        if (cand_over) state_nxt = asps_pkg::S_FINISH;
        else if (divides && co_differs) state_nxt = asps_pkg::S_ADDCO;
        else state_nxt = asps_pkg::S_START;
      end
      asps_pkg::S_ADDCO: state_nxt = asps_pkg::S_START;
      asps_pkg::S_FINISH: begin
        if (!out_valid_r || out_ready) state_nxt = asps_pkg::S_IDLE;
      end
      default: state_nxt = asps_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    add_en    = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      asps_pkg::S_IDLE:   in_ready  = 1'b1;
      asps_pkg::S_START:  div_start = 1'b1;
      asps_pkg::S_CHECK:  add_en    = !cand_over && divides;
      asps_pkg::S_ADDCO:  add_en    = 1'b1;
      asps_pkg::S_FINISH: load_out  = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign saturate = |acc_r[asps_pkg::ACC_BITS-1:asps_pkg::SUM_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= asps_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accepted) begin
      num_r   <= in_number;
      cand_r  <= asps_pkg::NUM_BITS'(2);
      acc_r   <= asps_pkg::ACC_BITS'(1);
      small_r <= in_number < asps_pkg::NUM_BITS'(2);
    end else begin
      if (add_en) acc_r <= acc_sum;
      // The candidate moves on after its check, or after the cofactor step when it divides with a differing cofactor.
      if ((state_r == asps_pkg::S_CHECK && !cand_over && !(divides && co_differs))
          || state_r == asps_pkg::S_ADDCO) begin
        cand_r <= cand_r + asps_pkg::NUM_BITS'(1);
      end
    end
    if (load_out) begin
      if (small_r) begin
        sum_out_r  <= '0;
        perf_out_r <= 1'b0;
      end else begin
        sum_out_r  <= saturate ? {asps_pkg::SUM_BITS{1'b1}}
                               : acc_r[asps_pkg::SUM_BITS-1:0];
        perf_out_r <= (acc_r == asps_pkg::ACC_BITS'(num_r));
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_divisor_sum = sum_out_r;
  assign out_is_perfect  = perf_out_r;

  // The divider only completes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == asps_pkg::S_WAIT)
    else $error("divider finished outside the wait state");

  // Every candidate tried is at least two.
  a_cand_min: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == asps_pkg::S_CHECK |-> cand_r >= asps_pkg::NUM_BITS'(2))
    else $error("candidate below two");

  // An accepted item always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accepted |=> state_r == asps_pkg::S_START || state_r == asps_pkg::S_FINISH)
    else $error("item accepted without starting work");

  // A perfect number has a nonzero sum.
  a_perfect_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_perfect |-> out_divisor_sum != '0)
    else $error("perfect flag with zero sum");

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for the aliquot sum and perfect number core
// Drives numbers through the valid/ready input channel with random gaps,
// predicts the proper divisor sum and the perfect flag of each accepted
// item, and checks every result in order while the result side stalls at
// random. Most numbers are kept small, since the core's run time grows
// with the square root of the number.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BITS = asps_pkg::NUM_BITS;
  localparam int S_BITS = asps_pkg::SUM_BITS;
  localparam longint unsigned SUM_MAX = (64'd1 << S_BITS) - 1;
  localparam int RANDOM_ITEMS = 81;

  typedef struct {
    logic [N_BITS-1:0] number;
    bit                drain;
  } number_req_t;

  typedef struct {
    logic [N_BITS-1:0] number;
    logic [S_BITS-1:0] sum;
    logic              perfect;
  } aliquot_exp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [N_BITS-1:0] in_number = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [S_BITS-1:0] out_divisor_sum;
  logic              out_is_perfect;

  number_req_t  number_q[$];
  aliquot_exp_t aliquot_q[$];
  int           issued = 0;
  int           taken = 0;
  int           errors = 0;
  int           hold_off = 0;
  int           stall = 0;
  bit           calm = 1'b0;

  aliquot_sum_perfect_test_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_divisor_sum (out_divisor_sum),
    .out_is_perfect  (out_is_perfect)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Sum of the proper divisors by trial division up to the square root.
  function automatic void aliquot_predict(input logic [N_BITS-1:0] n,
                                          output logic [S_BITS-1:0] sum,
                                          output logic perfect);
    longint unsigned val;
    longint unsigned total;
    longint unsigned cand;
    longint unsigned co;
    val = n;
    if (val < 2) begin
      sum = '0;
      perfect = 1'b0;
      return;
    end
    total = 1;
    for (cand = 2; cand <= val / cand; cand++) begin
      if (val % cand == 0) begin
        co = val / cand;
        total += cand;
        if (co != cand) total += co;
      end
    end
    perfect = (total == val);
    sum = (total > SUM_MAX) ? SUM_MAX[S_BITS-1:0] : total[S_BITS-1:0];
  endfunction

  // Mostly short gaps, now and then a long one; none during a calm stretch.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic queue_number(input logic [N_BITS-1:0] n, input bit drain);
    number_req_t req;
    req.number = n;
    req.drain = drain;
    number_q.push_back(req);
  endtask

  // Input driver: a new item is only offered once the previous one is taken.
  always @(negedge clk) begin : drive
    logic        go;
    number_req_t req;
    if (rst_n && issued == taken) begin
      go = 1'b0;
      if (hold_off > 0) begin
        hold_off--;
      end else if (number_q.size() > 0 &&
                   (!number_q[0].drain || aliquot_q.size() == 0)) begin
        req = number_q.pop_front();
        go = 1'b1;
        issued++;
        hold_off = pick_gap();
        if ($urandom_range(0, 9) == 0) calm = !calm;
      end
      in_valid <= go;
      if (go) in_number <= req.number;
    end
  end

  always @(negedge clk) begin : sink
    if (stall > 0) begin
      stall--;
      out_ready <= 1'b0;
    end else begin
      stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      out_ready <= (stall == 0);
    end
  end

  // Results are checked before new items are logged, so that a result and an
  // item on the same edge never pair up with each other.
  always @(posedge clk) begin : watch
    aliquot_exp_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (aliquot_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: sum %0d perfect %0b",
                                    out_divisor_sum, out_is_perfect));
        end else begin
          e = aliquot_q.pop_front();
          if (out_divisor_sum !== e.sum)
            report_mismatch($sformatf("number %0d: divisor_sum %0d, expected %0d",
                                      e.number, out_divisor_sum, e.sum));
          if (out_is_perfect !== e.perfect)
            report_mismatch($sformatf("number %0d: is_perfect %0b, expected %0b",
                                      e.number, out_is_perfect, e.perfect));
        end
      end
      if (in_valid && in_ready) begin
        e.number = in_number;
        aliquot_predict(in_number, e.sum, e.perfect);
        aliquot_q.push_back(e);
        taken++;
      end
    end
  end

  initial begin : stimulus
    int               r;
    int               w;
    int               k;
    logic [N_BITS-1:0] n;
    // Zero and one have no divisor sum; perfect numbers, squares where the
    // cofactor equals the divisor, primes, and the all-ones number.
    queue_number(0, 1'b0);
    queue_number(1, 1'b0);
    queue_number(2, 1'b0);
    queue_number(3, 1'b0);
    queue_number(4, 1'b0);
    queue_number(6, 1'b0);
    queue_number(9, 1'b0);
    queue_number(12, 1'b0);
    queue_number(16, 1'b0);
    queue_number(28, 1'b0);
    queue_number(36, 1'b0);
    queue_number(120, 1'b0);
    queue_number(496, 1'b0);
    queue_number(997, 1'b0);
    queue_number(8128, 1'b0);
    queue_number(65521, 1'b0);
    queue_number(65536, 1'b0);
    queue_number(33550336, 1'b0);
    queue_number('1, 1'b0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        k = $urandom_range(2, 1000);
        n = k * k;
      end else begin
        w = (r < 88) ? $urandom_range(2, 16) : $urandom_range(17, 22);
        n = $urandom & ((32'd1 << w) - 1);
      end
      // The first random item waits for the directed part to drain.
      queue_number(n, i == 0 || $urandom_range(0, 19) == 0);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (number_q.size() > 0 || issued != taken) @(posedge clk);
    while (aliquot_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #80_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
src/asps_pkg.sv
src/asps_div.sv
src/aliquot_sum_perfect_test_core.sv
tb/tb.sv
